// ===== src/rcpa_pkg.sv =====
package rcpa_pkg;

    localparam int PageBits     = 15;
    localparam int CountOutBits = 8;
    localparam int CfgDataBits  = 16;
    localparam int DefNumPages  = 32768;
    localparam int DefCountBits = 8;

    localparam logic [PageBits-1:0]    LowestPageReset = '0;
    localparam logic [CfgDataBits-1:0] TopPageReset    = 16'd32768;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_ADD_REF = 2'd2,
        OP_SEED    = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_RANGE = 3'd2,
        ST_COUNT = 3'd3,
        ST_OVER  = 3'd4
    } t_status;

    typedef enum logic {
        CFG_LOWEST_PAGE = 1'b0,
        CFG_TOP_PAGE    = 1'b1
    } t_cfg_reg;

endpackage

// ===== src/rcpa_ram.sv =====
module rcpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/refcounted_page_allocator.sv =====
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_opcode, i_page_index
// result    out        o_out_valid / i_out_stall o_result_page, o_status,
//                                                o_count_after, o_returned_to_pool
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Release, add reference and seed finish in the execute state; allocate goes on to the allocate
// state, since the count read at the popped page waits for the stack top read (one read port per memory).
// After reset the count memory is swept to zero, address by address, while no item is
// taken; config writes are taken at any time.
// A result waits in the output register; the next item is taken once it is gone.
module refcounted_page_allocator import rcpa_pkg::*; #(
    parameter int NUM_PAGES  = DefNumPages,
    parameter int COUNT_BITS = DefCountBits
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_opcode,
    input  logic [PageBits-1:0]     i_page_index,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [PageBits-1:0]     o_result_page,
    output logic [2:0]              o_status,
    output logic [CountOutBits-1:0] o_count_after,
    output logic                    o_returned_to_pool,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic                    i_cfg_index,
    input  logic [CfgDataBits-1:0]  i_cfg_data
);

    localparam int PAGE_AW = $clog2(NUM_PAGES);
    localparam int TOP_W   = $clog2(NUM_PAGES + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
    localparam logic [TOP_W-1:0]      TOP_FULL  = TOP_W'(NUM_PAGES);
    localparam logic [PAGE_AW-1:0]    CLR_LAST  = PAGE_AW'(NUM_PAGES - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_ALLOC
    } t_state;

    t_state                  r_state, n_state;
    logic [PAGE_AW-1:0]      r_clr_addr, n_clr_addr;
    logic [TOP_W-1:0]        r_free_top, n_free_top;
    logic [PageBits-1:0]     r_lowest, n_lowest;
    logic [CfgDataBits-1:0]  r_top, n_top;
    t_opcode                 r_op, n_op;
    logic [PageBits-1:0]     r_page, n_page;
    logic [PageBits-1:0]     r_q, n_q;
    logic                    r_out_valid, n_out_valid;
    logic [PageBits-1:0]     r_out_page, n_out_page;
    t_status                 r_out_status, n_out_status;
    logic [CountOutBits-1:0] r_out_count, n_out_count;
    logic                    r_out_ret, n_out_ret;

    logic                    in_accept;
    logic                    page_ok, q_ok, stack_empty, stack_full;
    logic                    cnt_we;
    logic [PAGE_AW-1:0]      cnt_waddr, cnt_raddr;
    logic [COUNT_BITS-1:0]   cnt_wdata, cnt_rdata;
    logic                    stk_we;
    logic [PAGE_AW-1:0]      stk_raddr;
    logic [TOP_W-1:0]        top_minus_one;
    logic [PageBits-1:0]     stk_rdata;

    rcpa_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_PAGES)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    rcpa_ram #(
        .WIDTH (PageBits),
        .DEPTH (NUM_PAGES)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_free_top[PAGE_AW-1:0]),
        .i_wdata (r_page),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // stack read port always follows the top entry
    assign top_minus_one = r_free_top - TOP_W'(1);
    assign stk_raddr     = top_minus_one[PAGE_AW-1:0];
    assign cnt_raddr     = (r_state == S_EXEC) ? PAGE_AW'(stk_rdata) : PAGE_AW'(i_page_index);

    assign in_accept   = (r_state == S_IDLE) && (!r_out_valid || !i_out_stall) && i_in_valid;
    assign o_in_stall  = !((r_state == S_IDLE) && (!r_out_valid || !i_out_stall));
    assign o_cfg_ready = 1'b1;

    assign stack_empty = (r_free_top == '0);
    assign stack_full  = (r_free_top >= TOP_FULL);
    assign page_ok     = (r_page >= r_lowest) && ({1'b0, r_page} < r_top)
                         && (32'(r_page) < 32'(NUM_PAGES));
    assign q_ok        = (32'(r_q) < 32'(NUM_PAGES));

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_free_top   = r_free_top;
        n_lowest     = r_lowest;
        n_top        = r_top;
        n_op         = r_op;
        n_page       = r_page;
        n_q          = r_q;
        n_out_valid  = r_out_valid;
        n_out_page   = r_out_page;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_ret    = r_out_ret;
        cnt_we       = 1'b0;
        cnt_waddr    = PAGE_AW'(r_page);
        cnt_wdata    = '0;
        stk_we       = 1'b0;

        if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_LOWEST_PAGE: n_lowest = i_cfg_data[PageBits-1:0];
                CFG_TOP_PAGE:    n_top    = i_cfg_data;
                default:         n_top    = r_top;
            endcase
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                cnt_we     = 1'b1;
                cnt_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + PAGE_AW'(1);
                if (r_clr_addr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_op    = t_opcode'(i_opcode);
                    n_page  = i_page_index;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_out_page   = r_page;
                n_out_status = ST_OK;
                n_out_count  = CountOutBits'(cnt_rdata);
                n_out_ret    = 1'b0;
                n_state      = S_IDLE;
                n_out_valid  = 1'b1;
                if (r_op == OP_ALLOC) begin
                    if (stack_empty) begin
                        n_out_page   = '0;
                        n_out_status = ST_EMPTY;
                        n_out_count  = '0;
                    end else begin
                        n_q         = stk_rdata;
                        n_out_valid = 1'b0;
                        n_state     = S_ALLOC;
                    end
                end else if (!page_ok) begin
                    n_out_status = ST_RANGE;
                    n_out_count  = '0;
                end else begin
                    case (r_op)
                        OP_RELEASE: begin
                            if (cnt_rdata == '0) begin
                                n_out_status = ST_COUNT;
                            end else if (cnt_rdata == COUNT_ONE) begin
                                if (stack_full) begin
                                    n_out_status = ST_COUNT;
                                end else begin
                                    cnt_we      = 1'b1;
                                    stk_we      = 1'b1;
                                    n_free_top  = r_free_top + TOP_W'(1);
                                    n_out_count = '0;
                                    n_out_ret   = 1'b1;
                                end
                            end else begin
                                cnt_we      = 1'b1;
                                cnt_wdata   = cnt_rdata - COUNT_ONE;
                                n_out_count = CountOutBits'(cnt_wdata);
                            end
                        end
                        OP_ADD_REF: begin
                            if (cnt_rdata == '0) begin
                                n_out_status = ST_COUNT;
                            end else if (cnt_rdata == COUNT_MAX) begin
                                n_out_status = ST_OVER;
                            end else begin
                                cnt_we      = 1'b1;
                                cnt_wdata   = cnt_rdata + COUNT_ONE;
                                n_out_count = CountOutBits'(cnt_wdata);
                            end
                        end
                        default: begin
                            if (stack_full) begin
                                n_out_status = ST_COUNT;
                            end else begin
                                cnt_we      = 1'b1;
                                stk_we      = 1'b1;
                                n_free_top  = r_free_top + TOP_W'(1);
                                n_out_count = '0;
                                n_out_ret   = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                n_out_valid  = 1'b1;
                n_out_page   = r_q;
                n_out_ret    = 1'b0;
                n_state      = S_IDLE;
                cnt_waddr    = PAGE_AW'(r_q);
                if (!q_ok) begin
                    n_out_status = ST_COUNT;
                    n_out_count  = '0;
                end else if (cnt_rdata != '0) begin
                    n_out_status = ST_COUNT;
                    n_out_count  = CountOutBits'(cnt_rdata);
                end else begin
                    cnt_we       = 1'b1;
                    cnt_wdata    = COUNT_ONE;
                    n_free_top   = top_minus_one;
                    n_out_status = ST_OK;
                    n_out_count  = CountOutBits'(COUNT_ONE);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_free_top  <= '0;
            r_lowest    <= LowestPageReset;
            r_top       <= TopPageReset;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_free_top  <= n_free_top;
            r_lowest    <= n_lowest;
            r_top       <= n_top;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_page       <= n_page;
        r_q          <= n_q;
        r_out_page   <= n_out_page;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_ret    <= n_out_ret;
    end

    assign o_out_valid        = r_out_valid;
    assign o_result_page      = r_out_page;
    assign o_status           = r_out_status;
    assign o_count_after      = r_out_count;
    assign o_returned_to_pool = r_out_ret;

endmodule

// ===== tb/refcounted_page_allocator_test.sv =====
module refcounted_page_allocator_test;
    import rcpa_pkg::*;

    localparam int NumPages = DefNumPages;
    localparam logic [CountOutBits-1:0] CountMax = '1;
    localparam int IdlePct = 37;
    localparam int MaxReports = 20;

    typedef struct packed {
        logic [PageBits-1:0]     page;
        t_status                 status;
        logic [CountOutBits-1:0] count;
        logic                    returned;
    } t_page_result;

    typedef struct packed {
        t_opcode             op;
        logic [PageBits-1:0] page;
        logic                typed;
        t_page_result        want;
    } t_dir_row;

    // window for these rows: lowest_page 4, top_page 40, fresh after reset
    localparam t_dir_row DirRows [22] = '{
        '{OP_ALLOC,   15'h7fff, 1'b1, '{15'd0,    ST_EMPTY, 8'd0, 1'b0}},
        '{OP_RELEASE, 15'd4,    1'b1, '{15'd4,    ST_COUNT, 8'd0, 1'b0}},
        '{OP_ADD_REF, 15'd39,   1'b1, '{15'd39,   ST_COUNT, 8'd0, 1'b0}},
        '{OP_SEED,    15'd3,    1'b1, '{15'd3,    ST_RANGE, 8'd0, 1'b0}},
        '{OP_SEED,    15'd40,   1'b1, '{15'd40,   ST_RANGE, 8'd0, 1'b0}},
        '{OP_RELEASE, 15'h7fff, 1'b1, '{15'h7fff, ST_RANGE, 8'd0, 1'b0}},
        '{OP_ADD_REF, 15'd0,    1'b1, '{15'd0,    ST_RANGE, 8'd0, 1'b0}},
        '{OP_SEED,    15'd4,    1'b1, '{15'd4,    ST_OK,    8'd0, 1'b1}},
        '{OP_SEED,    15'd39,   1'b1, '{15'd39,   ST_OK,    8'd0, 1'b1}},
        '{OP_ALLOC,   15'd0,    1'b1, '{15'd39,   ST_OK,    8'd1, 1'b0}},
        '{OP_ADD_REF, 15'd39,   1'b0, '0},
        '{OP_RELEASE, 15'd39,   1'b0, '0},
        '{OP_SEED,    15'd4,    1'b0, '0},
        '{OP_ALLOC,   15'h5555, 1'b0, '0},
        '{OP_ALLOC,   15'h2aaa, 1'b0, '0},
        '{OP_RELEASE, 15'd4,    1'b0, '0},
        '{OP_ALLOC,   15'h1234, 1'b0, '0},
        '{OP_ALLOC,   15'h0f0f, 1'b0, '0},
        '{OP_SEED,    15'd4,    1'b0, '0},
        '{OP_RELEASE, 15'd39,   1'b0, '0},
        '{OP_RELEASE, 15'd39,   1'b0, '0},
        '{OP_ADD_REF, 15'd4,    1'b0, '0}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic [1:0]              i_opcode = OP_ALLOC;
    logic [PageBits-1:0]     i_page_index = '0;
    logic                    i_out_stall = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    i_cfg_index = CFG_LOWEST_PAGE;
    logic [CfgDataBits-1:0]  i_cfg_data = '0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic [PageBits-1:0]     o_result_page;
    logic [2:0]              o_status;
    logic [CountOutBits-1:0] o_count_after;
    logic                    o_returned_to_pool;
    logic                    o_cfg_ready;

    refcounted_page_allocator u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_opcode           (i_opcode),
        .i_page_index       (i_page_index),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_result_page      (o_result_page),
        .o_status           (o_status),
        .o_count_after      (o_count_after),
        .o_returned_to_pool (o_returned_to_pool),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow allocator state
    logic [CountOutBits-1:0] page_refs [NumPages];
    logic [PageBits-1:0]     free_pages [NumPages];
    int unsigned             free_depth = 0;
    logic [PageBits-1:0]     win_lo = LowestPageReset;
    logic [CfgDataBits-1:0]  win_top = TopPageReset;

    t_page_result pending_results [$];
    t_page_result want;
    bit           idle_on = 1'b1;
    int           mismatches = 0;
    int           items_sent = 0;
    int           windows_used = 0;
    int           status_hits [5] = '{default: 0};

    initial begin
        foreach (page_refs[i]) page_refs[i] = '0;
    end

    function automatic t_page_result apply_page_op(t_opcode op, logic [PageBits-1:0] page);
        t_page_result r;
        logic [CountOutBits-1:0] c;
        logic [PageBits-1:0] q;
        r.page = page;
        r.status = ST_OK;
        r.count = '0;
        r.returned = 1'b0;
        if (op == OP_ALLOC) begin
            if (free_depth == 0) begin
                r.page = '0;
                r.status = ST_EMPTY;
                return r;
            end
            q = free_pages[free_depth - 1];
            r.page = q;
            if (page_refs[q] != 0) begin
                r.status = ST_COUNT;
                r.count = page_refs[q];
                return r;
            end
            page_refs[q] = 1;
            free_depth--;
            r.count = 1;
            return r;
        end
        if (page < win_lo || {1'b0, page} >= win_top) begin
            r.status = ST_RANGE;
            return r;
        end
        c = page_refs[page];
        r.count = c;
        case (op)
            OP_RELEASE: begin
                if (c == 0 || (c == 1 && free_depth >= NumPages)) begin
                    r.status = ST_COUNT;
                end else if (c == 1) begin
                    page_refs[page] = 0;
                    free_pages[free_depth++] = page;
                    r.count = 0;
                    r.returned = 1'b1;
                end else begin
                    page_refs[page] = c - 1;
                    r.count = c - 1;
                end
            end
            OP_ADD_REF: begin
                if (c == 0) begin
                    r.status = ST_COUNT;
                end else if (c >= CountMax) begin
                    r.status = ST_OVER;
                end else begin
                    page_refs[page] = c + 1;
                    r.count = c + 1;
                end
            end
            default: begin
                if (free_depth >= NumPages) begin
                    r.status = ST_COUNT;
                end else begin
                    page_refs[page] = 0;
                    free_pages[free_depth++] = page;
                    r.count = 0;
                    r.returned = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [PageBits-1:0] pick_page();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80 && win_top > win_lo)
            return PageBits'(win_lo + $urandom_range(0, int'(win_top) - int'(win_lo) - 1));
        if (r < 90)
            return $urandom_range(0, 1) ? PageBits'(win_lo - 1) : PageBits'(win_top);
        return PageBits'($urandom);
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= idle_on && ($urandom_range(0, 99) < IdlePct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MaxReports)
                    $display("%0t: unexpected item: page %0d status %0d count %0d returned %0b",
                             $time, o_result_page, o_status, o_count_after,
                             o_returned_to_pool);
            end else begin
                want = pending_results.pop_front();
                status_hits[want.status]++;
                if (o_result_page !== want.page || o_status !== want.status ||
                    o_count_after !== want.count || o_returned_to_pool !== want.returned) begin
                    mismatches++;
                    if (mismatches <= MaxReports)
                        $display({"%0t: mismatch: expected page %0d status %0d count %0d ",
                                  "returned %0b, got page %0d status %0d count %0d returned %0b"},
                                 $time, want.page, want.status, want.count, want.returned,
                                 o_result_page, o_status, o_count_after, o_returned_to_pool);
                end
            end
        end
    end

    task automatic send_item(input t_opcode op, input logic [PageBits-1:0] page,
                             input logic typed, input t_page_result typed_want);
        t_page_result predicted;
        if (idle_on && $urandom_range(0, 99) < IdlePct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_page_index <= page;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = apply_page_op(op, page);
        pending_results.push_back(typed ? typed_want : predicted);
        items_sent++;
    endtask

    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic set_window(input logic [PageBits-1:0] lo, input logic [CfgDataBits-1:0] top);
        wait_results_done();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_LOWEST_PAGE;
        i_cfg_data <= CfgDataBits'(lo);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        win_lo = lo;
        i_cfg_index <= CFG_TOP_PAGE;
        i_cfg_data <= top;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        win_top = top;
        i_cfg_valid <= 1'b0;
        windows_used++;
    endtask

    // seed, allocate, pump the count past saturation, then release back to the pool
    task automatic pump_page(input logic [PageBits-1:0] page);
        send_item(OP_SEED, page, 1'b0, '0);
        send_item(OP_ALLOC, PageBits'($urandom), 1'b0, '0);
        repeat ($urandom_range(256, 262)) send_item(OP_ADD_REF, page, 1'b0, '0);
        repeat ($urandom_range(255, 258)) send_item(OP_RELEASE, page, 1'b0, '0);
    endtask

    task automatic run_random(input int n);
        int unsigned r;
        repeat (n) begin
            if ($urandom_range(0, 99) == 0)
                wait_results_done();
            r = $urandom_range(0, 99);
            if (r < 30)
                send_item(OP_ALLOC, PageBits'($urandom), 1'b0, '0);
            else if (r < 55)
                send_item(OP_RELEASE, pick_page(), 1'b0, '0);
            else if (r < 80)
                send_item(OP_ADD_REF, pick_page(), 1'b0, '0);
            else
                send_item(OP_SEED, pick_page(), 1'b0, '0);
        end
    endtask

    initial begin
        logic [PageBits-1:0] lo;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_window(15'd4, 16'd40);
        foreach (DirRows[i])
            send_item(DirRows[i].op, DirRows[i].page, DirRows[i].typed, DirRows[i].want);

        lo = PageBits'($urandom_range(0, 32700));
        set_window(lo, CfgDataBits'(lo) + CfgDataBits'($urandom_range(8, 48)));
        pump_page(lo + 15'd3);
        run_random(200);

        // tight window with no idling on either side
        set_window(15'd0, 16'd16);
        idle_on = 1'b0;
        run_random(250);
        idle_on = 1'b1;

        set_window(15'd32767, 16'd32768);
        run_random(60);
        set_window(15'd0, 16'd0);
        run_random(40);
        set_window(15'd32752, 16'd32768);
        run_random(250);
        lo = PageBits'($urandom_range(0, 32700));
        set_window(lo, CfgDataBits'(lo) + CfgDataBits'($urandom_range(8, 64)));
        run_random(250);

        wait_results_done();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d items over %0d page windows, one count pumped past saturation",
                 items_sent, windows_used);
        $display("Results: %0d ok, %0d empty, %0d range, %0d count, %0d overflow",
                 status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_RANGE],
                 status_hits[ST_COUNT], status_hits[ST_OVER]);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("Timeout with %0d items still expected", pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
src/rcpa_pkg.sv
src/rcpa_ram.sv
src/refcounted_page_allocator.sv
tb/refcounted_page_allocator_test.sv
